// ===== design/tdls_pkg.sv =====
// ----------------------------------------------------------------------------
// tdls_pkg
// Shared types and constants for the link delay shaper: field widths,
// result kinds, sequencer states and the control/status bundles.
// ----------------------------------------------------------------------------
package tdls_pkg;

  localparam int TAG_W  = 16;
  localparam int OPP_W  = 4;
  localparam int TIME_W = 32;
  localparam int KIND_W = 2;
  localparam int DLY_W  = 16;

  localparam int DELAY_DEPTH_DEF   = 64;
  localparam int PENDING_DEPTH_DEF = 64;
  localparam int MAX_SLOTS_DEF     = 15;

  localparam logic [DLY_W-1:0] RESET_DELAY_MS = 16'd30;

  // APB map: one 32-bit register per word
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_DELAY_MS = 1'b0;

  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACCEPT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DROP    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARR,
    ST_MV_RD,
    ST_MV_CHK,
    ST_DLV_SET,
    ST_DLV_RD,
    ST_DLV_OUT
  } state_t;

  typedef struct packed {
    logic take_item;
    logic arr_commit;
    logic mv_read;
    logic mv_commit;
    logic dlv_load;
    logic dlv_read;
    logic dlv_emit;
  } ctrl_t;

  typedef struct packed {
    logic dly_empty;
    logic pnd_full;
    logic released;
    logic remain_zero;
    logic out_free;
  } stat_t;

endpackage

// ===== design/trace_driven_link_delay_shaper.sv =====
// ----------------------------------------------------------------------------
// trace_driven_link_delay_shaper
// Link emulator: fixed delay FIFO followed by trace-driven delivery slots.
// Arrival: the accept or drop result is registered in ST_ARR after accept.
// Tick: accept, then a read and a check per packet moved to the pending FIFO;
// the scan stops at an empty delay FIFO, full pending FIFO or unreleased head;
// then setup, a read and emit per delivered packet. A stalled output holds the sequence.
// One item at a time; s_tready is low until all of an item's results are loaded.
// Reset clears time, FIFO pointers and sets delay_ms to 30; RAMs keep contents.
// ----------------------------------------------------------------------------
module trace_driven_link_delay_shaper #(
  parameter int DELAY_DEPTH   = tdls_pkg::DELAY_DEPTH_DEF,
  parameter int PENDING_DEPTH = tdls_pkg::PENDING_DEPTH_DEF,
  parameter int MAX_SLOTS     = tdls_pkg::MAX_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [23:0]                  s_tdata,   // packet_tag[15:0], opportunities[19:16]
  input  logic                         s_tuser,   // cmd
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [15:0]                  m_tdata,   // packet_tag_res[15:0]
  output logic [1:0]                   m_tuser,   // kind
  output logic                         m_tlast,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tdls_pkg::APB_AW-1:0]  paddr,
  input  logic [tdls_pkg::APB_DW-1:0]  pwdata,
  output logic [tdls_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);

  import tdls_pkg::*;

  logic [DLY_W-1:0] delay_ms;
  logic             apb_wr;
  ctrl_t            ctrl;
  stat_t            stat;

  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_DELAY_MS) ? APB_DW'(delay_ms) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ms <= RESET_DELAY_MS;
    end else if (apb_wr && paddr[2] == REG_DELAY_MS) begin
      delay_ms <= pwdata[DLY_W-1:0];
    end
  end

  tdls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_cmd   (s_tuser),
    .in_ready (s_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  tdls_dp #(
    .DELAY_DEPTH   (DELAY_DEPTH),
    .PENDING_DEPTH (PENDING_DEPTH),
    .MAX_SLOTS     (MAX_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .in_cmd    (s_tuser),
    .in_tag    (s_tdata[TAG_W-1:0]),
    .in_opp    (s_tdata[TAG_W+OPP_W-1:TAG_W]),
    .delay_ms  (delay_ms),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (m_tuser),
    .out_tag   (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

// ===== design/tdls_ram.sv =====
// ----------------------------------------------------------------------------
// tdls_ram
// Simple dual-port RAM: one write port, one read port with registered,
// enable-held read data.
// ----------------------------------------------------------------------------
module tdls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/tdls_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdls_ctrl
// Sequencer: accepts one item, then steps the datapath through the
// arrival phase, or the release and delivery phases for a tick.
// ----------------------------------------------------------------------------
module tdls_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_cmd,
  output logic            in_ready,
  input  tdls_pkg::stat_t stat,
  output tdls_pkg::ctrl_t ctrl
);

  import tdls_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_cmd == CMD_TICK) ? ST_MV_RD : ST_ARR;
        end
      end
      ST_ARR: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_MV_RD: begin
        if (!stat.dly_empty && !stat.pnd_full) begin
          state_next = ST_MV_CHK;
        end else begin
          state_next = ST_DLV_SET;
        end
      end
      ST_MV_CHK: begin
        state_next = stat.released ? ST_MV_RD : ST_DLV_SET;
      end
      ST_DLV_SET: begin
        state_next = ST_DLV_RD;
      end
      ST_DLV_RD: begin
        state_next = stat.remain_zero ? ST_IDLE : ST_DLV_OUT;
      end
      ST_DLV_OUT: begin
        if (stat.out_free) begin
          state_next = ST_DLV_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl     = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready       = 1'b1;
        ctrl.take_item = in_valid;
      end
      ST_ARR: begin
        ctrl.arr_commit = stat.out_free;
      end
      ST_MV_RD: begin
        ctrl.mv_read = !stat.dly_empty && !stat.pnd_full;
      end
      ST_MV_CHK: begin
        ctrl.mv_commit = stat.released;
      end
      ST_DLV_SET: begin
        ctrl.dlv_load = 1'b1;
      end
      ST_DLV_RD: begin
        ctrl.dlv_read = !stat.remain_zero;
      end
      ST_DLV_OUT: begin
        ctrl.dlv_emit = stat.out_free;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

endmodule

// ===== design/tdls_dp.sv =====
// ----------------------------------------------------------------------------
// tdls_dp
// Datapath: millisecond clock, delay and pending FIFOs, the shared 32-bit
// add/subtract unit, slot counter and the output register.
// ----------------------------------------------------------------------------
module tdls_dp #(
  parameter int DELAY_DEPTH   = tdls_pkg::DELAY_DEPTH_DEF,
  parameter int PENDING_DEPTH = tdls_pkg::PENDING_DEPTH_DEF,
  parameter int MAX_SLOTS     = tdls_pkg::MAX_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tdls_pkg::ctrl_t              ctrl,
  output tdls_pkg::stat_t              stat,
  input  logic                         in_cmd,
  input  logic [tdls_pkg::TAG_W-1:0]   in_tag,
  input  logic [tdls_pkg::OPP_W-1:0]   in_opp,
  input  logic [tdls_pkg::DLY_W-1:0]   delay_ms,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tdls_pkg::KIND_W-1:0]  out_kind,
  output logic [tdls_pkg::TAG_W-1:0]   out_tag,
  output logic                         out_last
);

  import tdls_pkg::*;

  localparam int DAW = $clog2(DELAY_DEPTH);
  localparam int DCW = $clog2(DELAY_DEPTH + 1);
  localparam int PAW = $clog2(PENDING_DEPTH);
  localparam int PCW = $clog2(PENDING_DEPTH + 1);
  localparam int SW  = $clog2(MAX_SLOTS + 1);
  localparam int OW  = (SW > OPP_W) ? SW : OPP_W;
  localparam int NW  = (SW > PCW) ? SW : PCW;
  localparam int DRW = TIME_W + TAG_W;

  logic [TIME_W-1:0] now_ms;
  logic              cmd_r;
  logic [TAG_W-1:0]  tag_r;
  logic [OPP_W-1:0]  opp_r;

  logic [DAW-1:0] dly_head;
  logic [DAW-1:0] dly_tail;
  logic [DCW-1:0] dly_count;
  logic [PAW-1:0] pnd_head;
  logic [PAW-1:0] pnd_tail;
  logic [PCW-1:0] pnd_count;
  logic [SW-1:0]  remain;

  logic [DRW-1:0]   dram_rdata;
  logic [TAG_W-1:0] pram_rdata;
  logic             dly_full;
  logic             dram_we;

  // shared add/subtract unit
  logic              alu_sub;
  logic [TIME_W-1:0] alu_b;
  logic [TIME_W-1:0] alu_y;

  logic [OW-1:0] opp_ext;
  logic [SW-1:0] opp_lim;
  logic [SW-1:0] slots;

  logic out_load;

  function automatic logic [DAW-1:0] dly_inc(input logic [DAW-1:0] p);
    dly_inc = (p == DAW'(DELAY_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PAW-1:0] pnd_inc(input logic [PAW-1:0] p);
    pnd_inc = (p == PAW'(PENDING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign alu_sub = ctrl.mv_commit || !ctrl.arr_commit;
  assign alu_b   = alu_sub ? dram_rdata[DRW-1:TAG_W] : TIME_W'(delay_ms);
  assign alu_y   = alu_sub ? (now_ms - alu_b) : (now_ms + alu_b);

  assign dly_full = (dly_count == DCW'(DELAY_DEPTH));
  assign dram_we  = ctrl.arr_commit && !dly_full;

  assign opp_ext = OW'(opp_r);
  assign opp_lim = (opp_ext > OW'(MAX_SLOTS)) ? SW'(MAX_SLOTS) : SW'(opp_ext);
  assign slots   = (NW'(opp_lim) > NW'(pnd_count)) ? SW'(pnd_count) : opp_lim;

  assign out_load = ctrl.arr_commit || ctrl.dlv_emit;

  assign stat.dly_empty   = (dly_count == '0);
  assign stat.pnd_full    = (pnd_count == PCW'(PENDING_DEPTH));
  assign stat.released    = !alu_y[TIME_W-1];
  assign stat.remain_zero = (remain == '0);
  assign stat.out_free    = !out_valid || out_ready;

  tdls_ram #(
    .WIDTH (DRW),
    .DEPTH (DELAY_DEPTH)
  ) u_dly_ram (
    .clk   (clk),
    .we    (dram_we),
    .waddr (dly_tail),
    .wdata ({alu_y, tag_r}),
    .re    (ctrl.mv_read),
    .raddr (dly_head),
    .rdata (dram_rdata)
  );

  tdls_ram #(
    .WIDTH (TAG_W),
    .DEPTH (PENDING_DEPTH)
  ) u_pnd_ram (
    .clk   (clk),
    .we    (ctrl.mv_commit),
    .waddr (pnd_tail),
    .wdata (dram_rdata[TAG_W-1:0]),
    .re    (ctrl.dlv_read),
    .raddr (pnd_head),
    .rdata (pram_rdata)
  );

  always_ff @(posedge clk) begin
    if (ctrl.take_item) begin
      cmd_r <= in_cmd;
      tag_r <= in_tag;
      opp_r <= in_opp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms    <= '0;
      dly_head  <= '0;
      dly_tail  <= '0;
      dly_count <= '0;
      pnd_head  <= '0;
      pnd_tail  <= '0;
      pnd_count <= '0;
      remain    <= '0;
    end else begin
      if (ctrl.take_item && in_cmd == CMD_TICK) begin
        now_ms <= now_ms + 1'b1;
      end
      if (dram_we) begin
        dly_tail  <= dly_inc(dly_tail);
        dly_count <= dly_count + 1'b1;
      end
      if (ctrl.mv_commit) begin
        dly_head  <= dly_inc(dly_head);
        dly_count <= dly_count - 1'b1;
        pnd_tail  <= pnd_inc(pnd_tail);
        pnd_count <= pnd_count + 1'b1;
      end
      if (ctrl.dlv_load) begin
        remain <= slots;
      end
      if (ctrl.dlv_emit) begin
        pnd_head  <= pnd_inc(pnd_head);
        pnd_count <= pnd_count - 1'b1;
        remain    <= remain - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.arr_commit) begin
      out_kind <= dly_full ? KIND_DROP : KIND_ACCEPT;
      out_tag  <= tag_r;
      out_last <= 1'b1;
    end else if (ctrl.dlv_emit) begin
      out_kind <= KIND_DELIVER;
      out_tag  <= pram_rdata;
      out_last <= (remain == SW'(1));
    end
  end

  a_dly_bound: assert property (@(posedge clk) disable iff (rst)
    dly_count <= DCW'(DELAY_DEPTH))
    else $error("delay FIFO count overflow");

  a_pnd_bound: assert property (@(posedge clk) disable iff (rst)
    pnd_count <= PCW'(PENDING_DEPTH))
    else $error("pending FIFO count overflow");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctrl.dlv_emit |-> (pnd_count != '0) && (remain != '0))
    else $error("delivery from empty pending FIFO");

  a_move_room: assert property (@(posedge clk) disable iff (rst)
    ctrl.mv_commit |-> (dly_count != '0) && !stat.pnd_full)
    else $error("move without entry or room");

  a_arrival_cmd: assert property (@(posedge clk) disable iff (rst)
    ctrl.arr_commit |-> cmd_r == CMD_ARRIVE)
    else $error("arrival commit on a tick item");

endmodule

// ===== tb/sv/tb_trace_driven_link_delay_shaper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trace_driven_link_delay_shaper
// Self-checking bench for the link delay shaper. A directed plan covers the
// reset state, field extremes, release ordering after a delay change and
// delivery slot limits. Random bursts of arrivals and millisecond ticks then
// run under several delay settings and handshake stall patterns. A flood
// fills the delay FIFO until it drops packets and then fills the pending
// FIFO. Every output item is compared with an in-bench model of both FIFOs
// and the millisecond clock.
// ----------------------------------------------------------------------------
module tb_trace_driven_link_delay_shaper;
  import tdls_pkg::*;

  localparam int DRAIN_CYCLES = 2 * DELAY_DEPTH_DEF + 2 * MAX_SLOTS_DEF + 8;
  localparam int STALL_LIMIT  = 5000;
  localparam logic [APB_AW-1:0] ADDR_DELAY_MS = APB_AW'(4 * REG_DELAY_MS);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag;
    logic              fin;
  } link_res_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_op_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ACCEPT} row_chk_e;

  typedef struct packed {
    row_op_e          op;
    logic             cmd;
    logic [TAG_W-1:0] tag;
    logic [OPP_W-1:0] opp;
    logic [DLY_W-1:0] val;
    row_chk_e         chk;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [23:0]       s_tdata;   // packet_tag[15:0], opportunities[19:16]
  logic              s_tuser;   // cmd
  logic              m_tvalid;
  logic              m_tready;
  logic [15:0]       m_tdata;   // packet_tag_res[15:0]
  logic [1:0]        m_tuser;   // kind
  logic              m_tlast;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // model state
  logic [TIME_W-1:0] ms_now;
  logic [DLY_W-1:0]  delay_reg;
  logic [TIME_W-1:0] held_rel [DELAY_DEPTH_DEF];
  logic [TAG_W-1:0]  held_tag [DELAY_DEPTH_DEF];
  int                held_head;
  int                held_cnt;
  logic [TAG_W-1:0]  ready_tag [PENDING_DEPTH_DEF];
  int                ready_head;
  int                ready_cnt;
  link_res_t         link_out_q [$];

  int send_gap_pct;
  int recv_stall_pct;
  int errs = 0;
  int n_arrive = 0;
  int n_tick = 0;
  int n_deliv = 0;
  int n_accept = 0;
  int n_drop = 0;
  int stall_cycles = 0;

  plan_row_t plan [23];

  trace_driven_link_delay_shaper dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // append one expected output item
  function automatic void queue_res(link_res_t r);
    link_out_q.insert(link_out_q.size(), r);
  endfunction

  // arrival: queue with release time, or drop when full; tick: advance, release heads, deliver
  function automatic void shape_item(logic cmd, logic [TAG_W-1:0] tag,
                                     logic [OPP_W-1:0] opp, bit keep);
    int n;
    int slot;
    logic [TIME_W-1:0] age;
    if (cmd == CMD_ARRIVE) begin
      if (held_cnt >= DELAY_DEPTH_DEF) begin
        if (keep) queue_res(link_res_t'{KIND_DROP, tag, 1'b1});
        return;
      end
      slot = (held_head + held_cnt) % DELAY_DEPTH_DEF;
      held_rel[slot] = ms_now + {{(TIME_W-DLY_W){1'b0}}, delay_reg};
      held_tag[slot] = tag;
      held_cnt++;
      if (keep) queue_res(link_res_t'{KIND_ACCEPT, tag, 1'b1});
      return;
    end
    ms_now = ms_now + 1;
    while (held_cnt > 0 && ready_cnt < PENDING_DEPTH_DEF) begin
      age = ms_now - held_rel[held_head];
      if (age[TIME_W-1]) break;
      ready_tag[(ready_head + ready_cnt) % PENDING_DEPTH_DEF] = held_tag[held_head];
      ready_cnt++;
      held_head = (held_head + 1) % DELAY_DEPTH_DEF;
      held_cnt--;
    end
    n = (int'(opp) < MAX_SLOTS_DEF) ? int'(opp) : MAX_SLOTS_DEF;
    if (n > ready_cnt) n = ready_cnt;
    for (int k = 0; k < n; k++) begin
      if (keep) queue_res(link_res_t'{KIND_DELIVER, ready_tag[ready_head], k == n - 1});
      ready_head = (ready_head + 1) % PENDING_DEPTH_DEF;
      ready_cnt--;
    end
  endfunction

  function automatic logic [OPP_W-1:0] pick_opp();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return OPP_W'($urandom_range(15));
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(logic cmd, logic [TAG_W-1:0] tag, logic [OPP_W-1:0] opp,
                           row_chk_e chk);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {4'b0, opp, tag};
    do @(posedge clk); while (!s_tready);
    shape_item(cmd, tag, opp, chk == CHK_MODEL);
    if (chk == CHK_ACCEPT) queue_res(link_res_t'{KIND_ACCEPT, tag, 1'b1});
    if (cmd == CMD_ARRIVE) n_arrive++;
    else n_tick++;
    @(negedge clk);
  endtask

  task automatic set_delay(logic [DLY_W-1:0] val);
    logic [APB_DW-1:0] rd;
    s_tvalid <= 1'b0;
    while (link_out_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_DELAY_MS;
    pwdata  <= APB_DW'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    delay_reg = val;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== APB_DW'(val)) begin
      $error("delay_ms readback: expected %0d, got %0d", val, rd);
      errs++;
    end
  endtask

  task automatic run_bursts(int items, int arr_max);
    int sent;
    int na;
    int nt;
    sent = 0;
    while (sent < items) begin
      na = $urandom_range(arr_max);
      nt = $urandom_range(8, 1);
      repeat (na) send_item(CMD_ARRIVE, TAG_W'($urandom), OPP_W'($urandom), CHK_MODEL);
      repeat (nt) send_item(CMD_TICK, TAG_W'($urandom), pick_opp(), CHK_MODEL);
      sent += na + nt;
    end
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    link_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (link_out_q.size() == 0) begin
        $error("unexpected output item: kind %0d, tag %h", m_tuser, m_tdata);
        errs++;
      end else begin
        want = link_out_q.pop_front();
        if (m_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, m_tuser);
          errs++;
        end
        if (m_tdata !== want.tag) begin
          $error("packet_tag_res: expected %h, got %h", want.tag, m_tdata);
          errs++;
        end
        if (m_tlast !== want.fin) begin
          $error("last: expected %0d, got %0d", want.fin, m_tlast);
          errs++;
        end
      end
      case (m_tuser)
        KIND_DELIVER: n_deliv++;
        KIND_ACCEPT:  n_accept++;
        KIND_DROP:    n_drop++;
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("no handshake for %0d cycles", STALL_LIMIT);
    $display("tb_trace_driven_link_delay_shaper: done, errors");
    $finish;
  end

  initial begin
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = CMD_ARRIVE;
    m_tready = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    rst      = 1'b1;
    ms_now     = '0;
    delay_reg  = RESET_DELAY_MS;
    held_head  = 0;
    held_cnt   = 0;
    ready_head = 0;
    ready_cnt  = 0;
    send_gap_pct   = 13;
    recv_stall_pct = 54;

    plan = '{
      '{ROW_ITEM, CMD_TICK,   16'h0000, 4'd0,  16'd0, CHK_NONE},
      '{ROW_ITEM, CMD_TICK,   16'hFFFF, 4'd15, 16'd0, CHK_NONE},
      '{ROW_CFG,  CMD_ARRIVE, 16'h0000, 4'd0,  16'd0, CHK_MODEL},
      '{ROW_ITEM, CMD_ARRIVE, 16'h0000, 4'd15, 16'd0, CHK_ACCEPT},
      '{ROW_ITEM, CMD_ARRIVE, 16'hFFFF, 4'd0,  16'd0, CHK_ACCEPT},
      '{ROW_ITEM, CMD_ARRIVE, 16'hA5A5, 4'd5,  16'd0, CHK_ACCEPT},
      '{ROW_ITEM, CMD_ARRIVE, 16'h5A5A, 4'd10, 16'd0, CHK_ACCEPT},
      '{ROW_ITEM, CMD_TICK,   16'h0000, 4'd1,  16'd0, CHK_MODEL},
      '{ROW_ITEM, CMD_TICK,   16'h0000, 4'd15, 16'd0, CHK_MODEL},
      '{ROW_ITEM, CMD_TICK,   16'h0000, 4'd15, 16'd0, CHK_MODEL},
      '{ROW_CFG,  CMD_ARRIVE, 16'h0000, 4'd0,  16'd2, CHK_MODEL},
      '{ROW_ITEM, CMD_ARRIVE, 16'h1234, 4'd0,  16'd0, CHK_ACCEPT},
      '{ROW_ITEM, CMD_TICK,   16'h0000, 4'd15, 16'd0, CHK_MODEL},
      '{ROW_ITEM, CMD_TICK,   16'h0000, 4'd8,  16'd0, CHK_MODEL},
      // later packet with shorter delay waits behind the head
      '{ROW_CFG,  CMD_ARRIVE, 16'h0000, 4'd0,  16'd5, CHK_MODEL},
      '{ROW_ITEM, CMD_ARRIVE, 16'h0001, 4'd0,  16'd0, CHK_ACCEPT},
      '{ROW_CFG,  CMD_ARRIVE, 16'h0000, 4'd0,  16'd1, CHK_MODEL},
      '{ROW_ITEM, CMD_ARRIVE, 16'h8000, 4'd0,  16'd0, CHK_ACCEPT},
      '{ROW_ITEM, CMD_TICK,   16'h0000, 4'd15, 16'd0, CHK_MODEL},
      '{ROW_ITEM, CMD_TICK,   16'h0000, 4'd15, 16'd0, CHK_MODEL},
      '{ROW_ITEM, CMD_TICK,   16'h0000, 4'd15, 16'd0, CHK_MODEL},
      '{ROW_ITEM, CMD_TICK,   16'h0000, 4'd15, 16'd0, CHK_MODEL},
      '{ROW_ITEM, CMD_TICK,   16'h0000, 4'd15, 16'd0, CHK_MODEL}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].op == ROW_CFG) set_delay(plan[i].val);
      else send_item(plan[i].cmd, plan[i].tag, plan[i].opp, plan[i].chk);
    end

    set_delay(RESET_DELAY_MS);
    run_bursts(40, 6);

    send_gap_pct   = 54;
    recv_stall_pct = 13;
    set_delay(16'd1);
    run_bursts(35, 4);
    set_delay(16'd7);
    run_bursts(30, 5);

    // flood: overflow the delay FIFO, then fill the pending FIFO
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    set_delay(16'd0);
    repeat (8) send_item(CMD_TICK, TAG_W'($urandom), '1, CHK_MODEL);
    repeat (68) send_item(CMD_ARRIVE, TAG_W'($urandom), OPP_W'($urandom), CHK_MODEL);
    send_item(CMD_TICK, TAG_W'($urandom), '0, CHK_MODEL);
    repeat (10) send_item(CMD_ARRIVE, TAG_W'($urandom), OPP_W'($urandom), CHK_MODEL);
    send_item(CMD_TICK, TAG_W'($urandom), '0, CHK_MODEL);
    repeat (6) send_item(CMD_TICK, TAG_W'($urandom), '1, CHK_MODEL);

    set_delay(16'hFFFF);
    repeat (12) send_item(CMD_ARRIVE, TAG_W'($urandom), OPP_W'($urandom), CHK_MODEL);
    repeat (6) send_item(CMD_TICK, TAG_W'($urandom), pick_opp(), CHK_MODEL);

    s_tvalid <= 1'b0;
    while (link_out_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d arrivals and %0d ticks at delays 0, 1, 2, 5, 7, 30 and 65535",
             n_arrive, n_tick);
    $display("observed %0d deliveries, %0d accepts and %0d drops",
             n_deliv, n_accept, n_drop);
    if (errs == 0) begin
      $display("tb_trace_driven_link_delay_shaper: done, clean");
    end else begin
      $display("tb_trace_driven_link_delay_shaper: done, errors");
    end
    $finish;
  end

endmodule
